>>> hw/rtl/cubic_bspline_sampler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic B-spline sampler
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BSPLINE_SAMPLER_TOP_MACROS_SVH
`define CUBIC_BSPLINE_SAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define CBS_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared widths, types and helpers of the cubic B-spline sampler.
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int COORD_W     = 32;
    localparam int LEN_W       = 40;
    localparam int IDX_W       = 6;
    localparam int NCFG_W      = 7;
    localparam int MAX_SAMPLES = 64;
    localparam int N_MIN       = 2;
    localparam int N_RESET     = 16;
    localparam int W_W         = 21;
    localparam int PROD_W      = 54;
    localparam int ACC_W       = 56;
    localparam int DVD_W       = 54;
    localparam int DVS_W       = 21;
    localparam int QUO_W       = 34;
    localparam int DIFF_W      = 33;
    localparam int SQ_W        = 66;
    localparam int RAD_W       = 68;
    localparam int ROOT_W      = 35;
    localparam int REM_W       = 37;
    localparam int SRT_ITER    = RAD_W / 2;
    localparam int CNT_W       = 6;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [2:0][COORD_W-1:0] t_point;

    typedef struct packed {
        logic [NCFG_W-1:0] n;
        t_point [3:0]      pts;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE, S_SEG1, S_SEG2, S_WGT1, S_WGT2, S_WGT3, S_MUL, S_ADD,
        S_DIVS, S_DIVW, S_SQ, S_SUM, S_SQS, S_SQW, S_OUT
    } t_bstate;

    function automatic logic [NCFG_W-1:0] clamp_n(input logic [NCFG_W-1:0] v);
        logic [NCFG_W-1:0] r;
        r = v;
        if (v < NCFG_W'(N_MIN)) r = NCFG_W'(N_MIN);
        if (v > NCFG_W'(MAX_SAMPLES)) r = NCFG_W'(MAX_SAMPLES);
        return r;
    endfunction

endpackage

>>> hw/rtl/cbs_if.sv
// ----------------------------------------------------------------------------
// cbs_if
// Point and sample channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbs_point_if import cbs_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    modport source(output valid, point_x, point_y, point_z, input ready);
    modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface cbs_sample_if import cbs_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
    logic signed [COORD_W-1:0] sample_z;
    logic [LEN_W-1:0]          arc_length;
    logic [IDX_W-1:0]          sample_index;
    logic                      last_of_segment;
    modport source(output valid, sample_x, sample_y, sample_z, arc_length,
                   sample_index, last_of_segment, input ready);
    modport sink(input valid, sample_x, sample_y, sample_z, arc_length,
                 sample_index, last_of_segment, output ready);
endinterface

>>> hw/rtl/cbs_front.sv
// ----------------------------------------------------------------------------
// cbs_front
// Accepts control points, keeps the three-point window, queues segments.
// ----------------------------------------------------------------------------
module cbs_front import cbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cbs_point_if.sink         i_point,
    input  logic [NCFG_W-1:0] i_n,
    input  logic              i_q_full,
    output logic              o_push,
    output t_job              o_job
);

    t_point [2:0] r_win;
    logic [1:0]   r_seen;
    t_point       w_p3;
    logic         w_acc;

    assign i_point.ready = !i_q_full;
    assign w_acc         = i_point.valid && i_point.ready;
    assign w_p3          = {i_point.point_z, i_point.point_y, i_point.point_x};
    assign o_push        = w_acc && (r_seen == 2'd3);
    assign o_job.n       = i_n;
    assign o_job.pts     = {w_p3, r_win[2], r_win[1], r_win[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_win  <= '0;
        end else if (w_acc) begin
            if (r_seen != 2'd3) r_seen <= r_seen + 2'd1;
            r_win <= {w_p3, r_win[2], r_win[1]};
        end
    end

endmodule

>>> hw/rtl/cbs_queue.sv
// ----------------------------------------------------------------------------
// cbs_queue
// Two-entry segment queue between front and back.
// ----------------------------------------------------------------------------
module cbs_queue import cbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> hw/rtl/cbs_div.sv
// ----------------------------------------------------------------------------
// cbs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbs_div import cbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dvd,
    input  logic [DVS_W-1:0]   i_dvs,
    output logic               o_busy,
    output logic [COORD_W-1:0] o_quo
);

    logic [DVS_W-1:0] r_rem;
    logic [QUO_W-1:0] r_low;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DVS_W:0]   w_t;
    logic             w_ge;

    assign w_t    = {r_rem, r_low[QUO_W-1]};
    assign w_ge   = w_t >= {1'b0, i_dvs};
    assign o_busy = r_busy;
    assign o_quo  = r_low[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DVS_W'(i_dvd[DVD_W-1:QUO_W]);
            r_low <= i_dvd[QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? DVS_W'(w_t - {1'b0, i_dvs}) : w_t[DVS_W-1:0];
            r_low <= {r_low[QUO_W-2:0], w_ge};
        end
    end

endmodule

>>> hw/rtl/cbs_sqrt.sv
// ----------------------------------------------------------------------------
// cbs_sqrt
// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module cbs_sqrt import cbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [REM_W+1:0]  w_rn;
    logic [REM_W+1:0]  w_tr;
    logic              w_ge;

    assign w_rn   = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_tr   = {2'b00, r_root, 2'b01};
    assign w_ge   = w_rn >= w_tr;
    assign o_busy = r_busy;
    assign o_root = r_root + ROOT_W'(REM_W'(r_root) < r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(SRT_ITER);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? REM_W'(w_rn - w_tr) : REM_W'(w_rn);
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

endmodule

>>> hw/rtl/cbs_back.sv
// ----------------------------------------------------------------------------
// cbs_back
// Evaluates one segment sample by sample: weights, MAC, divide, distance.
// ----------------------------------------------------------------------------
module cbs_back import cbs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_job,
    output logic      o_pop,
    cbs_sample_if.source o_sample
);

    t_bstate r_state, n_state;
    t_job    r_job;

    logic [12:0]      r_n2, r_m2, r_jn;
    logic [18:0]      r_n3, r_w0, r_jnn;
    logic [11:0]      r_j2;
    logic [17:0]      r_j3, r_j2n;
    logic [IDX_W-1:0] r_j;
    logic [1:0]       r_k;
    logic [W_W-1:0]   r_w [4];

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_acc [3];
    t_point                   r_cur, r_prev;
    logic [SQ_W-1:0]          r_sq [3];
    logic [RAD_W-1:0]         r_rad;
    logic [LEN_W-1:0]         r_ds, r_len;

    logic                  r_ovalid;
    t_point                r_opt;
    logic [LEN_W-1:0]      r_olen;
    logic [IDX_W-1:0]      r_oidx;
    logic                  r_olast;

    logic [NCFG_W-1:0]  w_m;
    logic [DVS_W-1:0]   w_d;
    logic [23:0]        w_j3e, w_j2ne, w_jnne, w_n3e;
    logic [W_W-1:0]     w_w1, w_w2;
    logic [2:0]         w_dbusy;
    logic [COORD_W-1:0] w_quo [3];
    logic               w_sbusy;
    logic [ROOT_W-1:0]  w_root;
    logic               w_last, w_free;
    logic               w_div_start, w_sqrt_start, w_load;

    assign w_m    = r_job.n - NCFG_W'(r_j);
    assign w_d    = DVS_W'(24'(r_n3) * 24'd6);
    assign w_j3e  = 24'(r_j3);
    assign w_j2ne = 24'(r_j2n);
    assign w_jnne = 24'(r_jnn);
    assign w_n3e  = 24'(r_n3);
    assign w_w1   = W_W'(24'(w_j3e * 24'd3 - w_j2ne * 24'd6 + w_n3e * 24'd4));
    assign w_w2   = W_W'(24'(w_j2ne * 24'd3 + w_jnne * 24'd3 + w_n3e - w_j3e * 24'd3));
    assign w_last = (NCFG_W'(r_j) == r_job.n - NCFG_W'(1));
    assign w_free = !r_ovalid || o_sample.ready;

    for (genvar c = 0; c < 3; c++) begin : g_div
        cbs_div u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(w_div_start),
            .i_dvd  (r_acc[c][DVD_W-1:0]),
            .i_dvs  (w_d),
            .o_busy (w_dbusy[c]),
            .o_quo  (w_quo[c])
        );
    end

    cbs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sqrt_start),
        .i_rad  (r_rad),
        .o_busy (w_sbusy),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state      = r_state;
        o_pop        = 1'b0;
        w_div_start  = 1'b0;
        w_sqrt_start = 1'b0;
        w_load       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = S_SEG1;
                end
            end
            S_SEG1: n_state = S_SEG2;
            S_SEG2: n_state = S_WGT1;
            S_WGT1: n_state = S_WGT2;
            S_WGT2: n_state = S_WGT3;
            S_WGT3: n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = (r_k == 2'd3) ? S_DIVS : S_MUL;
            S_DIVS: begin
                w_div_start = 1'b1;
                n_state     = S_DIVW;
            end
            S_DIVW: begin
                if (w_dbusy == 3'b000) n_state = (r_j == '0) ? S_OUT : S_SQ;
            end
            S_SQ:  n_state = S_SUM;
            S_SUM: n_state = S_SQS;
            S_SQS: begin
                w_sqrt_start = 1'b1;
                n_state      = S_SQW;
            end
            S_SQW: begin
                if (!w_sbusy) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    n_state = w_last ? S_IDLE : S_WGT1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_prev <= '0;
        end else if (w_load) begin
            r_prev <= r_cur;
            if (r_j != '0) begin
                if (r_ds >= LEN_MAX - r_len) r_len <= LEN_MAX;
                else                         r_len <= r_len + r_ds;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_q_valid) r_job <= i_job;
            S_SEG1: r_n2 <= 13'(r_job.n * r_job.n);
            S_SEG2: begin
                r_n3 <= 19'(r_n2 * 19'(r_job.n));
                r_j  <= '0;
            end
            S_WGT1: begin
                r_j2 <= 12'(r_j * r_j);
                r_m2 <= 13'(w_m * w_m);
                r_jn <= 13'(13'(r_j) * 13'(r_job.n));
            end
            S_WGT2: begin
                r_j3  <= 18'(r_j2 * 18'(r_j));
                r_w0  <= 19'(r_m2 * 19'(w_m));
                r_j2n <= 18'(r_j2 * 18'(r_job.n));
                r_jnn <= 19'(r_jn * 19'(r_job.n));
            end
            S_WGT3: begin
                r_w[0] <= W_W'(r_w0);
                r_w[1] <= w_w1;
                r_w[2] <= w_w2;
                r_w[3] <= W_W'(r_j3);
                r_k    <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= $signed(ACC_W'(w_n3e * 24'd3) + (ACC_W'(w_d) << COORD_W));
                end
            end
            S_MUL: begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[c] <= PROD_W'($signed({1'b0, r_w[r_k]})
                                 * $signed(r_job.pts[r_k][c]));
                end
            end
            S_ADD: begin
                r_k <= r_k + 2'd1;
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
                end
            end
            S_DIVW: begin
                for (int c = 0; c < 3; c++) r_cur[c] <= w_quo[c];
            end
            S_SQ: begin
                for (int c = 0; c < 3; c++) begin
                    logic signed [DIFF_W-1:0] dv;
                    logic [DIFF_W-1:0]        mg;
                    dv = $signed({r_cur[c][COORD_W-1], r_cur[c]})
                       - $signed({r_prev[c][COORD_W-1], r_prev[c]});
                    mg = dv[DIFF_W-1] ? DIFF_W'(-dv) : DIFF_W'(dv);
                    r_sq[c] <= SQ_W'(mg * mg);
                end
            end
            S_SUM: r_rad <= RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]);
            S_SQW: r_ds <= LEN_W'(w_root);
            S_OUT: if (w_load) r_j <= r_j + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_sample.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_opt   <= r_cur;
            r_oidx  <= r_j;
            r_olast <= w_last;
            if (r_j == '0)                    r_olen <= r_len;
            else if (r_ds >= LEN_MAX - r_len) r_olen <= LEN_MAX;
            else                              r_olen <= r_len + r_ds;
        end
    end

    assign o_sample.valid           = r_ovalid;
    assign o_sample.sample_x        = r_opt[0];
    assign o_sample.sample_y        = r_opt[1];
    assign o_sample.sample_z        = r_opt[2];
    assign o_sample.arc_length      = r_olen;
    assign o_sample.sample_index    = r_oidx;
    assign o_sample.last_of_segment = r_olast;

endmodule

>>> hw/rtl/cubic_bspline_sampler_top.sv
// ----------------------------------------------------------------------------
// cubic_bspline_sampler_top
// Uniform cubic B-spline sampler with running arc length.
// Samples are computed one at a time by the 34-step dividers and square root
// (item 0 skips the square root); the next one starts once the previous one
//   is loaded into the output register, which must first be free or read.
// Reset (synchronous, i_rst_n low) clears window, arc length and queue; N = 16.
// ----------------------------------------------------------------------------
`include "cubic_bspline_sampler_top_macros.svh"

module cubic_bspline_sampler_top import cbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cbs_point_if.sink         i_point,
    cbs_sample_if.source      o_sample,
    input  logic              i_cfg_we,
    input  logic [NCFG_W-1:0] i_cfg_wdata
);

    logic [NCFG_W-1:0] r_spc;
    logic [NCFG_W-1:0] w_n;
    logic              w_push, w_full, w_q_valid, w_pop;
    t_job              w_job_in, w_job_out;
    logic              w_olast;
    logic [NCFG_W-1:0] w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_spc <= NCFG_W'(N_RESET);
        else if (i_cfg_we) r_spc <= i_cfg_wdata;
    end

    assign w_n = clamp_n(r_spc);

    cbs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (i_point),
        .i_n     (w_n),
        .i_q_full(w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    cbs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job_in),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .o_job  (w_job_out),
        .i_pop  (w_pop)
    );

    cbs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_job    (w_job_out),
        .o_pop    (w_pop),
        .o_sample (o_sample)
    );

    assign w_olast = o_sample.valid && o_sample.last_of_segment;
    assign w_idx   = NCFG_W'(o_sample.sample_index);

    `CBS_IMPLY(a_last_idx, w_olast, w_idx == w_n - NCFG_W'(1), "last item index mismatch")
    `CBS_IMPLY(a_idx_range, o_sample.valid, w_idx < w_n, "item index beyond N")
    `CBS_IMPLY(a_pop_nonempty, w_pop, w_q_valid, "pop from empty queue")
    `CBS_NEXT(a_push_fill, w_push, w_q_valid, "queue empty after push")

endmodule
